>>> hw/rtl/cde_pkg.sv
`timescale 1ns / 1ps

package cde_pkg;

  // Defaults for the top-level parameters
  localparam int CDE_MAX_DEPTH = 16;
  localparam int CDE_WORD_BITS = 32;

  // Fixed field widths of the configuration and result ports
  localparam int CDE_CAP_BITS   = 5;
  localparam int CDE_COUNT_BITS = 5;

  // Capacity after reset, before it is clamped to the ring depth
  localparam int CDE_CAP_RESET = 16;

  // Operation codes carried by each input item
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } cde_op_t;

  // Status of one finished item, passed from control to the output stage
  typedef struct packed {
    logic                      accepted;
    logic                      is_empty;
    logic                      is_full;
    logic [CDE_COUNT_BITS-1:0] entry_count;
  } cde_status_t;

endpackage

>>> hw/rtl/cde_ring_mem.sv
`timescale 1ns / 1ps

module cde_ring_mem #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32,
  parameter int ADDR_W    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic [ADDR_W-1:0]    rd_addr_a,
  input  logic [ADDR_W-1:0]    rd_addr_b,
  output logic [WORD_BITS-1:0] rd_data_a,
  output logic [WORD_BITS-1:0] rd_data_b
);

  logic [WORD_BITS-1:0] ring_mem [DEPTH];

  // One write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports (front and rear)
  always_ff @(posedge clk) begin
    rd_data_a <= ring_mem[rd_addr_a];
    rd_data_b <= ring_mem[rd_addr_b];
  end

endmodule

>>> hw/rtl/cde_ctrl.sv
`timescale 1ns / 1ps

module cde_ctrl
  import cde_pkg::*;
#(
  parameter int MAX_DEPTH = CDE_MAX_DEPTH,
  parameter int WORD_BITS = CDE_WORD_BITS,
  parameter int PTR_W     = $clog2(MAX_DEPTH),
  parameter int CNT_W     = $clog2(MAX_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_op,
  input  logic [WORD_BITS-1:0]    in_value,
  // capacity register
  input  logic                    cfg_wr_en,
  input  logic [CDE_CAP_BITS-1:0] cfg_wr_data,
  // ring store ports
  output logic                    mem_wr_en,
  output logic [PTR_W-1:0]        mem_wr_addr,
  output logic [WORD_BITS-1:0]    mem_wr_data,
  output logic [PTR_W-1:0]        mem_rd_addr_a,
  output logic [PTR_W-1:0]        mem_rd_addr_b,
  // finished item towards the output stage
  output logic                    res_valid,
  input  logic                    res_take,
  output cde_status_t             res_status
);

  localparam int CAP_RST = (CDE_CAP_RESET > MAX_DEPTH) ? MAX_DEPTH : CDE_CAP_RESET;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t           state_r,  state_nxt;
  logic [PTR_W-1:0] head_r,   head_nxt;
  logic [PTR_W-1:0] tail_r,   tail_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [CNT_W-1:0] cap_r,    cap_nxt;
  logic             acc_r,    acc_nxt;

  logic             item_acc;
  logic             is_full;
  logic             is_empty;
  logic [31:0]      cap_wide;
  logic [31:0]      cap_clamp;

  // Pointer step forward, wrapping at the capacity
  function automatic logic [PTR_W-1:0] wrap_up(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : PTR_W'(n);
  endfunction

  // Pointer step back, wrapping to the last entry within the capacity
  function automatic logic [PTR_W-1:0] wrap_down(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] last;
    last = cap - CNT_W'(1);
    if (p == '0 || CNT_W'(p) >= cap) begin
      return PTR_W'(last);
    end
    return p - PTR_W'(1);
  endfunction

  assign in_stall = (state_r != ST_IDLE);
  assign item_acc = in_valid && !in_stall;
  assign is_full  = (count_r == cap_r);
  assign is_empty = (count_r == '0);

  // Capacity clamp: zero reads as one, above the depth reads as the depth
  assign cap_wide = 32'(cfg_wr_data);
  always_comb begin
    if (cap_wide == 32'd0) begin
      cap_clamp = 32'd1;
    end else if (cap_wide > 32'(MAX_DEPTH)) begin
      cap_clamp = 32'(MAX_DEPTH);
    end else begin
      cap_clamp = cap_wide;
    end
  end

  // Operation decode, pointer update and store write
  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    cap_nxt     = cap_r;
    acc_nxt     = acc_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = in_value;

    if (cfg_wr_en) begin
      // any capacity write empties the deque
      cap_nxt   = CNT_W'(cap_clamp);
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else if (item_acc) begin
      acc_nxt = 1'b0;
      case (cde_op_t'(in_op))
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (!is_full) begin
            acc_nxt   = 1'b1;
            mem_wr_en = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            if (is_empty) begin
              // first item lands at entry zero
              head_nxt    = '0;
              tail_nxt    = '0;
              mem_wr_addr = '0;
            end else if (cde_op_t'(in_op) == OP_PUSH_FRONT) begin
              head_nxt    = wrap_down(head_r, cap_r);
              mem_wr_addr = head_nxt;
            end else begin
              tail_nxt    = wrap_up(tail_r, cap_r);
              mem_wr_addr = tail_nxt;
            end
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (!is_empty) begin
            acc_nxt   = 1'b1;
            count_nxt = count_r - CNT_W'(1);
            // last item out leaves the pointers where they are
            if (count_r > CNT_W'(1)) begin
              if (cde_op_t'(in_op) == OP_POP_FRONT) begin
                head_nxt = wrap_up(head_r, cap_r);
              end else begin
                tail_nxt = wrap_down(tail_r, cap_r);
              end
            end
          end
        end
        default: begin
          acc_nxt = 1'b0;
        end
      endcase
    end
  end

  // Sequencer: accept, read front and rear, hand over
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (item_acc && !cfg_wr_en) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      cap_r   <= CNT_W'(CAP_RST);
      acc_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Reads always follow the live pointers; data is valid in the done state
  assign mem_rd_addr_a = head_r;
  assign mem_rd_addr_b = tail_r;

  assign res_valid              = (state_r == ST_DONE);
  assign res_status.accepted    = acc_r;
  assign res_status.is_empty    = is_empty;
  assign res_status.is_full     = is_full;
  assign res_status.entry_count = CDE_COUNT_BITS'(count_r);

endmodule

>>> hw/rtl/circular_deque_engine_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_op, in_value
// out_     output     out_valid/out_stall  out_accepted, out_front_value, out_rear_value,
//                                          out_is_empty, out_is_full, out_entry_count
// cfg_     input      cfg_wr_en            cfg_wr_data (capacity in use)
//
// One item passes through accept and store write, front/rear read from the ring
// store (registered read), then load into the output register once it is free.
// A new item is taken while the previous result waits in the output register.
// Synchronous active-low rst_n empties the deque and sets capacity to min(16, MAX_DEPTH).
// out_stall holds the result; a second finished item waits in the done state.
module circular_deque_engine_top
  import cde_pkg::*;
#(
  parameter int MAX_DEPTH = CDE_MAX_DEPTH,
  parameter int WORD_BITS = CDE_WORD_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [WORD_BITS-1:0]      in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_accepted,
  output logic [WORD_BITS-1:0]      out_front_value,
  output logic [WORD_BITS-1:0]      out_rear_value,
  output logic                      out_is_empty,
  output logic                      out_is_full,
  output logic [CDE_COUNT_BITS-1:0] out_entry_count,
  input  logic                      cfg_wr_en,
  input  logic [CDE_CAP_BITS-1:0]   cfg_wr_data
);

  localparam int PTR_W = $clog2(MAX_DEPTH);
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);

  logic                 mem_wr_en;
  logic [PTR_W-1:0]     mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;
  logic [PTR_W-1:0]     mem_rd_addr_a;
  logic [PTR_W-1:0]     mem_rd_addr_b;
  logic [WORD_BITS-1:0] mem_rd_data_a;
  logic [WORD_BITS-1:0] mem_rd_data_b;
  logic                 res_valid;
  logic                 res_take;
  cde_status_t          res_status;

  logic                 out_valid_r, out_valid_nxt;
  cde_status_t          out_status_r;
  logic [WORD_BITS-1:0] front_r;
  logic [WORD_BITS-1:0] rear_r;

  cde_ctrl #(
    .MAX_DEPTH (MAX_DEPTH),
    .WORD_BITS (WORD_BITS),
    .PTR_W     (PTR_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_value      (in_value),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_addr_a (mem_rd_addr_a),
    .mem_rd_addr_b (mem_rd_addr_b),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res_status    (res_status)
  );

  cde_ring_mem #(
    .DEPTH     (MAX_DEPTH),
    .WORD_BITS (WORD_BITS),
    .ADDR_W    (PTR_W)
  ) u_ring_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_addr_a (mem_rd_addr_a),
    .rd_addr_b (mem_rd_addr_b),
    .rd_data_a (mem_rd_data_a),
    .rd_data_b (mem_rd_data_b)
  );

  // Output register: load when empty or being drained
  assign res_take      = res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload; an empty deque reports all ones at both ends
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status_r <= res_status;
      front_r      <= res_status.is_empty ? '1 : mem_rd_data_a;
      rear_r       <= res_status.is_empty ? '1 : mem_rd_data_b;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_status_r.accepted;
  assign out_front_value = front_r;
  assign out_rear_value  = rear_r;
  assign out_is_empty    = out_status_r.is_empty;
  assign out_is_full     = out_status_r.is_full;
  assign out_entry_count = out_status_r.entry_count;

endmodule
